[design/msb_first_bit_field_reader_unit_defines.svh]
// Assertion macros used by the bit-field reader top level.
// Depends on nothing; the module that uses them provides clk and arst_n.
`ifndef MSB_FIRST_BIT_FIELD_READER_UNIT_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_READER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MBFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bit field reader check failed");

// Check that cons holds in the cycle after ante.
`define MBFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bit field reader check failed");

`endif

[design/mbfr_pkg.sv]
// Shared constants, command codes and control types of the bit-field reader.
// Depends on nothing.
package mbfr_pkg;

	localparam int BUFFER_BYTES   = 4096;
	localparam int MAX_FIELD_BITS = 16;

	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int FIELD_W = 16;
	localparam int POS_W   = 16;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam int ADDR_W  = $clog2(BUFFER_BYTES);
	localparam int LEN_W   = $clog2(BUFFER_BYTES + 1);
	localparam int IDX_W   = POS_W - 2;
	localparam int CMP_W   = POS_W + 1;
	localparam int SUM_W   = POS_W + 2;
	localparam int CNT_W   = $clog2(MAX_FIELD_BITS + 1);
	localparam int WIN_BYTES = (MAX_FIELD_BITS + 14) / 8;
	localparam int WIN_W   = WIN_BYTES * 8;
	localparam int K_W     = $clog2(WIN_BYTES + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_READ   = 3'd2,
		CMD_PEEK   = 3'd3,
		CMD_SKIP   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic shift_en;
		logic byte_ok;
	} win_ctl_t;

endpackage

[design/mbfr_store.sv]
// Byte store of the bit-field reader: one write port, one registered read port.
// Depends on mbfr_pkg.
module mbfr_store
	import mbfr_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [BUFFER_BYTES];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/mbfr_window.sv]
// Bit window and field shifter: collects fetched bytes and cuts out the field.
// Depends on mbfr_pkg.
module mbfr_window
	import mbfr_pkg::*;
(
	input  logic               clk,
	input  win_ctl_t           ctl,
	input  logic [BYTE_W-1:0]  rd_data,
	input  logic [2:0]         bit_off,
	input  logic [CNT_W-1:0]   nbits,
	output logic [FIELD_W-1:0] field
);

	logic [WIN_W-1:0]          win_q;
	logic [BYTE_W-1:0]         byte_in;
	logic [WIN_W-1:0]          aligned;
	logic [MAX_FIELD_BITS-1:0] top_bits;
	logic [CNT_W-1:0]          rshift;

	// Bytes past the stored length read as zero.
	assign byte_in = ctl.byte_ok ? rd_data : '0;

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			win_q <= (win_q << BYTE_W) | WIN_W'(byte_in);
		end
	end

	// Drop the leading bit offset, keep the top field, right-align it.
	assign aligned  = win_q << bit_off;
	assign top_bits = aligned[WIN_W-1 -: MAX_FIELD_BITS];
	assign rshift   = CNT_W'(MAX_FIELD_BITS) - nbits;
	assign field    = FIELD_W'(top_bits >> rshift);

endmodule

[design/msb_first_bit_field_reader_unit.sv]
// Top level of the MSB-first bit-field reader: request sequencer, position and length.
// Depends on mbfr_pkg, mbfr_store, mbfr_window and the assertion macro header.
//
// Channel | Dir | Contents
// s_*     | in  | tuser: cmd[2:0]; tdata: byte_value[7:0], bit_count[23:8] (signed)
// m_*     | out | tdata: field_value[15:0], bit_position[31:16]
//
// Start, append, skip, unused codes, and a zero-bit or past-the-end read or peek go from
// idle straight to emit. A read or peek of 1..MAX_FIELD_BITS bits first runs WIN_BYTES
// fetch/load pairs (3 at 16 bits): the single store read port gives one byte per pair.
// arst_n clears length, position, sequencer and output valid; store contents stay.
// The store needs no clearing pass: bytes at or past the stored length read as zero.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and waits at the end of its work until the register frees up.
`include "msb_first_bit_field_reader_unit_defines.svh"

module msb_first_bit_field_reader_unit
	import mbfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // byte_value[7:0], bit_count[23:8]
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // field_value[15:0], bit_position[31:16]
);

	// Request fields
	logic                      s_accept;
	logic [CMD_W-1:0]          s_cmd;
	logic [BYTE_W-1:0]         s_byte;
	logic signed [COUNT_W-1:0] s_count;

	// Architectural state
	logic [LEN_W-1:0] len_q;
	logic [POS_W-1:0] pos_q;

	// Sequencer
	state_t             state_q, state_d;
	logic [K_W-1:0]     k_q;
	logic [IDX_W-1:0]   idx_q;
	logic [2:0]         off_q;
	logic [CNT_W-1:0]   n_q;
	logic               is_field_q;

	// Output register
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_value_q;
	logic [POS_W-1:0]   out_pos_q;

	// Datapath
	logic [CNT_W-1:0]       n_clamped;
	logic [CMP_W-1:0]       len_bits;
	logic                   past_end;
	logic                   need_fetch;
	logic signed [SUM_W-1:0] add_a, add_b, add_sum;
	logic [POS_W-1:0]       pos_clamped;
	logic                   store_full;
	logic                   fetch_last;

	// Control outputs
	logic        rd_en;
	win_ctl_t    win_ctl;
	logic        out_load;
	logic [BYTE_W-1:0]  rd_data;
	logic [FIELD_W-1:0] win_field;

	assign s_cmd    = s_tuser;
	assign s_byte   = s_tdata[7:0];
	assign s_count  = s_tdata[23:8];
	assign s_accept = s_tvalid && s_tready;

	// Saturate the field width to 0..MAX_FIELD_BITS.
	always_comb begin
		if (s_count < 0) begin
			n_clamped = '0;
		end else if (s_count > COUNT_W'(MAX_FIELD_BITS)) begin
			n_clamped = CNT_W'(MAX_FIELD_BITS);
		end else begin
			n_clamped = s_count[CNT_W-1:0];
		end
	end

	assign len_bits   = CMP_W'({len_q, 3'b000});
	assign past_end   = CMP_W'(pos_q) > len_bits;
	assign need_fetch = !past_end && (n_clamped != '0);
	assign store_full = (len_q >= LEN_W'(BUFFER_BYTES));

	// Shared position adder: field width for a read, signed distance for a skip.
	assign add_a   = SUM_W'(pos_q);
	assign add_b   = (s_cmd == CMD_READ) ? SUM_W'(n_clamped) : SUM_W'(s_count);
	assign add_sum = add_a + add_b;

	always_comb begin
		if (add_sum < 0) begin
			pos_clamped = '0;
		end else if (add_sum > SUM_W'(POS_MAX)) begin
			pos_clamped = POS_MAX;
		end else begin
			pos_clamped = add_sum[POS_W-1:0];
		end
	end

	assign fetch_last = (k_q == K_W'(WIN_BYTES - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (((s_cmd == CMD_READ) || (s_cmd == CMD_PEEK)) && need_fetch) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_FETCH: state_d = ST_LOAD;
			ST_LOAD: begin
				state_d = fetch_last ? ST_EMIT : ST_FETCH;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready         = 1'b0;
		rd_en            = 1'b0;
		win_ctl.shift_en = 1'b0;
		win_ctl.byte_ok  = (idx_q < IDX_W'(len_q));
		out_load         = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_FETCH: rd_en = 1'b1;
			ST_LOAD:  win_ctl.shift_en = 1'b1;
			ST_EMIT:  out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// State, length and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			pos_q      <= '0;
			k_q        <= '0;
			is_field_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_accept) begin
				k_q        <= '0;
				is_field_q <= 1'b0;
				case (s_cmd)
					CMD_START: begin
						len_q <= '0;
						pos_q <= '0;
					end
					CMD_APPEND: begin
						if (!store_full) begin
							len_q <= len_q + LEN_W'(1);
						end
					end
					CMD_READ: begin
						// advance only when the position is not past the end of the stream
						is_field_q <= need_fetch;
						if (!past_end) begin
							pos_q <= pos_clamped;
						end
					end
					CMD_PEEK: is_field_q <= need_fetch;
					CMD_SKIP: pos_q <= pos_clamped;
					default: ;
				endcase
			end else if (state_q == ST_LOAD) begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	// Fetch pointer and field geometry; payload, no reset
	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_q <= IDX_W'(pos_q >> 3);
			off_q <= pos_q[2:0];
			n_q   <= n_clamped;
		end else if (state_q == ST_LOAD) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= is_field_q ? win_field : '0;
			out_pos_q   <= pos_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pos_q, out_value_q};

	mbfr_store u_store (
		.clk     (clk),
		.wr_en   (s_accept && (s_cmd == CMD_APPEND) && !store_full),
		.wr_addr (len_q[ADDR_W-1:0]),
		.wr_data (s_byte),
		.rd_en   (rd_en),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	mbfr_window u_window (
		.clk     (clk),
		.ctl     (win_ctl),
		.rd_data (rd_data),
		.bit_off (off_q),
		.nbits   (n_q),
		.field   (win_field)
	);

	// Length never passes the store size.
	`MBFR_ASSERT_NOW(a_len_cap, 1'b1, len_q <= LEN_W'(BUFFER_BYTES))
	// The byte counter stays inside the window while loading.
	`MBFR_ASSERT_NOW(a_fetch_range, state_q == ST_LOAD, k_q < K_W'(WIN_BYTES))
	// An accepted request makes the block busy and drops s_tready.
	`MBFR_ASSERT_NEXT(a_busy_after, s_accept, !s_tready)
	// A peek never moves the position.
	`MBFR_ASSERT_NEXT(a_peek_hold, s_accept && (s_cmd == CMD_PEEK), pos_q == $past(pos_q))

endmodule

[bench/field_read_checker.sv]
// Checker for the MSB-first bit-field reader: tracks the byte stream and read
// position, predicts every result and compares it with the output channel.
// Depends on mbfr_pkg for widths, limits and command codes.
module field_read_checker
	import mbfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // byte_value[7:0], bit_count[23:8]
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // field_value[15:0], bit_position[31:16]
	output int          mismatch_count,
	output int          results_due
);

	typedef struct packed {
		logic [FIELD_W-1:0] field_value;
		logic [POS_W-1:0]   bit_position;
	} field_result_t;

	logic [BYTE_W-1:0] stream_bytes [BUFFER_BYTES];
	int unsigned       stream_len;
	int unsigned       cursor;
	field_result_t     field_results_due [$];

	function automatic int unsigned clamp_field_bits(int requested);
		if (requested < 0)
			return 0;
		if (requested > MAX_FIELD_BITS)
			return MAX_FIELD_BITS;
		return requested;
	endfunction

	// Collect nbits at the cursor, first bit ending up most significant.
	function automatic logic [FIELD_W-1:0] gather_bits(int unsigned nbits);
		logic [FIELD_W-1:0] acc;
		int unsigned        bp;
		logic               b;
		acc = '0;
		for (int unsigned i = 0; i < nbits; i++) begin
			bp = cursor + i;
			b  = 1'b0;
			if ((bp >> 3) < stream_len)
				b = stream_bytes[bp >> 3][7 - (bp & 7)];
			acc = {acc[FIELD_W-2:0], b};
		end
		return acc;
	endfunction

	function automatic void predict_field_read(input logic [CMD_W-1:0] op,
			input logic [BYTE_W-1:0] data_byte, input logic signed [COUNT_W-1:0] amount);
		field_result_t r;
		int unsigned   nbits;
		int            target;
		r.field_value = '0;
		case (op)
			CMD_START: begin
				stream_len = 0;
				cursor     = 0;
			end
			CMD_APPEND: begin
				if (stream_len < BUFFER_BYTES) begin
					stream_bytes[stream_len] = data_byte;
					stream_len++;
				end
			end
			CMD_READ, CMD_PEEK: begin
				nbits = clamp_field_bits(amount);
				// a cursor beyond the stream end yields zero and stays put
				if (cursor <= stream_len * 8) begin
					r.field_value = gather_bits(nbits);
					if (op == CMD_READ)
						cursor = (cursor + nbits > 32'(POS_MAX)) ? 32'(POS_MAX) :
							cursor + nbits;
				end
			end
			CMD_SKIP: begin
				target = int'(cursor) + amount;
				if (target < 0)
					target = 0;
				else if (target > int'(POS_MAX))
					target = int'(POS_MAX);
				cursor = target;
			end
			default: ;
		endcase
		r.bit_position = cursor[POS_W-1:0];
		field_results_due.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_result_t due;
		if (!arst_n) begin
			stream_len  = 0;
			cursor      = 0;
			field_results_due.delete();
			results_due = 0;
		end else begin
			// retire first: a result can never belong to a request taken this edge
			if (m_tvalid && m_tready) begin
				if (field_results_due.size() == 0) begin
					mismatch_count++;
					$error("unexpected result: field_value %h bit_position %h",
						m_tdata[15:0], m_tdata[31:16]);
				end else begin
					due = field_results_due.pop_front();
					if (m_tdata[15:0] !== due.field_value) begin
						mismatch_count++;
						$error("field_value mismatch: expected %h, actual %h",
							due.field_value, m_tdata[15:0]);
					end
					if (m_tdata[31:16] !== due.bit_position) begin
						mismatch_count++;
						$error("bit_position mismatch: expected %h, actual %h",
							due.bit_position, m_tdata[31:16]);
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_field_read(s_tuser, s_tdata[7:0], s_tdata[23:8]);
			results_due = field_results_due.size();
		end
	end

endmodule

[bench/tb.sv]
// Top of the bit-field reader bench: clock, reset, request stimulus and verdict.
// Depends on mbfr_pkg, msb_first_bit_field_reader_unit and field_read_checker.
module tb;
	import mbfr_pkg::*;

	localparam int IDLE_LIMIT      = 4000;  // cycles with no handshake at all
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_REQUESTS = 1600;
	localparam int TAIL_CYCLES     = 24;
	localparam int FILL_BYTES      = 96;

	// cmd codes that leave the block's state alone; each still returns a result
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef enum {
		SINK_OPEN,
		SINK_LOSSY,
		SINK_SPARSE,
		SINK_TOGGLE
	} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // byte_value[7:0], bit_count[23:8]
	logic [2:0]  s_tuser;  // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // field_value[15:0], bit_position[31:16]

	int mismatch_count;
	int results_due;
	int hold_req    = 0;  // bump to ask the sink for one long hold-off
	int burst_left  = 0;
	int random_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	msb_first_bit_field_reader_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	field_read_checker u_field_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	// Offer one request and hold it until the block takes it. Requests go out
	// in bursts; between bursts drop valid for a random gap, or sometimes
	// roll straight into the next burst so long unbroken stretches happen too.
	task automatic send_request(input logic [CMD_W-1:0] op,
			input logic [BYTE_W-1:0] data_byte, input logic signed [COUNT_W-1:0] amount);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {amount, data_byte};
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Drop valid and wait until every predicted result has come back.
	// Sample on the falling edge so the checker's count is settled.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		@(posedge clk);
	endtask

	// Field width for read/peek: mostly legal sizes, some saturating,
	// some negative, a few anywhere in the 16-bit range.
	function automatic logic signed [COUNT_W-1:0] field_bits();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return COUNT_W'($urandom_range(0, MAX_FIELD_BITS));
		if (roll < 90)
			return COUNT_W'($urandom_range(MAX_FIELD_BITS + 1, 40));
		if (roll < 95)
			return COUNT_W'(-$urandom_range(1, 20));
		return COUNT_W'($urandom);
	endfunction

	// Skip distance: mostly short hops both ways, sometimes long jumps.
	function automatic logic signed [COUNT_W-1:0] skip_distance();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return COUNT_W'($urandom_range(0, 80) - 40);
		if (roll < 85)
			return COUNT_W'($urandom_range(0, 400) - 200);
		return COUNT_W'($urandom);
	endfunction

	// One well-formed session: start, fill a short stream, then pull fields
	// out of it with noise (stray appends, restarts, ignored codes) mixed in.
	task automatic random_field_session();
		int nbytes;
		int nops;
		int ignored;
		int unsigned roll;
		ignored = 0;
		send_request(CMD_START, BYTE_W'($urandom), COUNT_W'($urandom));
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(0, 24);
		repeat (nbytes) send_request(CMD_APPEND, BYTE_W'($urandom), COUNT_W'($urandom));
		nops = $urandom_range(4, 30);
		repeat (nops) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				send_request(CMD_READ, BYTE_W'($urandom), field_bits());
			else if (roll < 60)
				send_request(CMD_PEEK, BYTE_W'($urandom), field_bits());
			else if (roll < 75)
				send_request(CMD_SKIP, BYTE_W'($urandom), skip_distance());
			else if (roll < 88)
				send_request(CMD_APPEND, BYTE_W'($urandom), COUNT_W'($urandom));
			else if (roll < 94) begin
				send_request(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
					BYTE_W'($urandom), COUNT_W'($urandom));
				ignored++;
			end else if (roll < 97)
				send_request(CMD_START, BYTE_W'($urandom), COUNT_W'($urandom));
			else
				send_request(CMD_READ, BYTE_W'($urandom), COUNT_W'($urandom));
		end
		random_sent += 1 + nbytes + nops - ignored;
	endtask

	// Result sink: stall on its own pattern of modes, and serve a long
	// hold-off whenever the stimulus asks for one.
	initial begin : result_sink
		sink_mode_t mode;
		int         hold_seen;
		int         mode_left;
		m_tready  = 1'b0;
		mode      = SINK_OPEN;
		hold_seen = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 120);
			end
			mode_left--;
			case (mode)
				SINK_OPEN:   m_tready <= 1'b1;
				SINK_LOSSY:  m_tready <= ($urandom_range(0, 2) != 0);
				SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:     m_tready <= ~m_tready;
			endcase
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL msb_first_bit_field_reader_unit");
		$finish;
	end

	initial begin : stimulus
		bit held;
		held     = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stream: a read at the very end yields zeros and still advances,
		// the next one starts beyond the end and must leave the position alone.
		send_request(CMD_START, 8'h00, 16'sd0);
		send_request(CMD_READ, 8'h00, 16'sd16);
		send_request(CMD_READ, 8'hff, 16'sd1);

		// Four bytes with the extreme values and mixed patterns.
		send_request(CMD_START, 8'hff, -16'sd1);
		send_request(CMD_APPEND, 8'hff, 16'sd0);
		send_request(CMD_APPEND, 8'h00, -16'sd1);
		send_request(CMD_APPEND, 8'ha5, 16'sd0);
		send_request(CMD_APPEND, 8'h3c, 16'sd0);
		send_request(CMD_PEEK, 8'h00, 16'sd16);
		// zero width, negative widths and saturating widths
		send_request(CMD_READ, 8'h00, 16'sd0);
		send_request(CMD_READ, 8'h00, -16'sd1);
		send_request(CMD_READ, 8'h00, -16'sd32768);
		send_request(CMD_READ, 8'h00, 16'sd3);
		send_request(CMD_READ, 8'h00, 16'sd32767);
		send_request(CMD_PEEK, 8'h00, 16'sd17);
		// this field runs over the end of the stream, then the cursor is past it
		send_request(CMD_READ, 8'h00, 16'sd16);
		send_request(CMD_READ, 8'h00, 16'sd1);
		// skip clamps at both ends of the position range
		send_request(CMD_SKIP, 8'h00, -16'sd32768);
		send_request(CMD_SKIP, 8'h00, 16'sd32767);
		send_request(CMD_SKIP, 8'h00, 16'sd32767);
		send_request(CMD_SKIP, 8'h00, 16'sd5);
		send_request(CMD_PEEK, 8'h00, 16'sd8);
		// ignored codes, with every data bit high
		send_request(CMD_UNUSED_FIRST, 8'hff, -16'sd1);
		send_request(CMD_UNUSED_LAST, 8'hff, -16'sd1);
		wait_drained();

		// Fill a longer stream, then read across the last byte and beyond it.
		send_request(CMD_START, 8'h00, 16'sd0);
		repeat (FILL_BYTES) send_request(CMD_APPEND, BYTE_W'($urandom), COUNT_W'($urandom));
		send_request(CMD_SKIP, 8'h00, COUNT_W'(FILL_BYTES * 8 - 5));
		send_request(CMD_PEEK, 8'h00, 16'sd16);
		send_request(CMD_READ, 8'h00, 16'sd16);
		send_request(CMD_READ, 8'h00, 16'sd16);
		send_request(CMD_SKIP, 8'h00, -16'sd32768);
		send_request(CMD_READ, 8'h00, 16'sd16);
		wait_drained();

		// Random sessions. Part way in, ask the sink for its long hold-off
		// while requests keep coming so the block backs up to its input.
		while (random_sent < RANDOM_REQUESTS) begin
			if (!held && random_sent >= RANDOM_REQUESTS / 3) begin
				hold_req <= hold_req + 1;
				held = 1'b1;
			end
			random_field_session();
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("PASS msb_first_bit_field_reader_unit");
		else
			$display("FAIL msb_first_bit_field_reader_unit");
		$finish;
	end

endmodule
